FILE: sv/fstb_pkg.sv
// shared types and constants for the flat span texture blender
`default_nettype none

package fstb_pkg;

    localparam int unsigned FUNC_W      = 3;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned SHADE_DEPTH = 256;
    localparam int unsigned BLEND_DEPTH = 65536;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_SPAN_START  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL       = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEXEL_WRITE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SHADE_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_BLEND_WRITE = 3'd4;

    // draw modes
    localparam logic [MODE_W-1:0] MODE_MASK_REPLACE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MASK_BLEND_SH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MASK_BLEND_DH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLEND_SH      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLEND_DH      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CHECKER       = 3'd5;

    // configuration register indexes
    localparam logic CFG_DRAW_MODE  = 1'b0;
    localparam logic CFG_MASK_COLOR = 1'b1;

    localparam logic [BYTE_W-1:0] CHECKER_DARK  = 8'd96;
    localparam logic [BYTE_W-1:0] CHECKER_LIGHT = 8'd111;

    typedef enum logic [1:0] {
        KIND_PIXEL       = 2'd0,
        KIND_TEXEL_WRITE = 2'd1,
        KIND_SHADE_WRITE = 2'd2,
        KIND_BLEND_WRITE = 2'd3
    } t_kind;

    // one queued work item; addr holds the texel index for pixels
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [1:0]         chk;
    } t_item;

    function automatic logic [BYTE_W-1:0] checker_value(input logic [1:0] pos);
        logic [BYTE_W-1:0] val;
        case (pos)
            2'd0:    val = CHECKER_DARK;
            2'd1:    val = CHECKER_LIGHT;
            2'd2:    val = CHECKER_LIGHT;
            2'd3:    val = CHECKER_DARK;
            default: val = CHECKER_DARK;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fstb_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fstb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/fstb_front.sv
// front end: takes input beats, keeps the u/v accumulators, queues work
`default_nettype none

module fstb_front
    import fstb_pkg::*;
#(
    parameter int unsigned TEX_SIDE_BITS = 6,
    parameter int unsigned FRAC_BITS     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [ADDR_W-1:0]  i_table_addr,
    input  wire logic [BYTE_W-1:0]  i_table_data,
    input  wire logic [COORD_W-1:0] i_u_start,
    input  wire logic [COORD_W-1:0] i_v_start,
    input  wire logic [COORD_W-1:0] i_u_step,
    input  wire logic [COORD_W-1:0] i_v_step,
    input  wire logic [BYTE_W-1:0]  i_old_pixel,
    input  wire logic               i_span_last,
    input  wire logic               i_full,
    output      logic               o_push,
    output      t_item              o_item
);

    localparam int unsigned TIDX_W = 2 * TEX_SIDE_BITS;

    logic [COORD_W-1:0] r_u_acc, r_v_acc, r_u_inc, r_v_inc;
    logic [COORD_W-1:0] n_u_acc, n_v_acc, n_u_inc, n_v_inc;
    logic               accept;
    logic [TIDX_W-1:0]  texel_idx;

    assign accept    = i_in_valid && !i_full;
    assign texel_idx = {r_v_acc[FRAC_BITS +: TEX_SIDE_BITS],
                        r_u_acc[FRAC_BITS +: TEX_SIDE_BITS]};

    always_comb begin
        n_u_acc     = r_u_acc;
        n_v_acc     = r_v_acc;
        n_u_inc     = r_u_inc;
        n_v_inc     = r_v_inc;
        o_push      = 1'b0;
        o_item.kind = KIND_PIXEL;
        o_item.addr = i_table_addr;
        o_item.data = i_table_data;
        o_item.last = i_span_last;
        o_item.chk  = {r_u_acc[FRAC_BITS + 2], r_v_acc[FRAC_BITS + 3]};
        if (accept) begin
            case (i_func)
                FUNC_SPAN_START: begin
                    n_u_acc = i_u_start;
                    n_v_acc = i_v_start;
                    n_u_inc = i_u_step;
                    n_v_inc = i_v_step;
                end
                FUNC_PIXEL: begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_PIXEL;
                    o_item.addr = ADDR_W'(texel_idx);
                    o_item.data = i_old_pixel;
                    n_u_acc     = r_u_acc + r_u_inc;
                    n_v_acc     = r_v_acc + r_v_inc;
                end
                FUNC_TEXEL_WRITE: begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_TEXEL_WRITE;
                end
                FUNC_SHADE_WRITE: begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_SHADE_WRITE;
                end
                FUNC_BLEND_WRITE: begin
                    o_push      = 1'b1;
                    o_item.kind = KIND_BLEND_WRITE;
                end
                default: begin
                    // unused codes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_acc <= '0;
            r_v_acc <= '0;
            r_u_inc <= '0;
            r_v_inc <= '0;
        end else begin
            r_u_acc <= n_u_acc;
            r_v_acc <= n_v_acc;
            r_u_inc <= n_u_inc;
            r_v_inc <= n_v_inc;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fstb_queue.sv
// short work queue between front and back
`default_nettype none

module fstb_queue
    import fstb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output      logic  o_full,
    output      logic  o_valid,
    output      t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("queue empty with pointers apart");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("queue push while full");

endmodule

`default_nettype wire

FILE: sv/fstb_back.sv
// back end: texel, shade and blend lookups and result register
`default_nettype none

module fstb_back
    import fstb_pkg::*;
#(
    parameter int unsigned TEX_SIDE_BITS = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_item             i_item,
    output      logic              o_pop,
    input  wire logic [MODE_W-1:0] i_draw_mode,
    input  wire logic [BYTE_W-1:0] i_mask_color,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      logic [BYTE_W-1:0] o_new_pixel,
    output      logic              o_write_enable,
    output      logic              o_span_end
);

    localparam int unsigned TIDX_W    = 2 * TEX_SIDE_BITS;
    localparam int unsigned TEX_DEPTH = 1 << TIDX_W;

    logic adv;

    // stage a: texel read
    logic              r_a_valid;
    t_item             r_a_item;
    logic [BYTE_W-1:0] texel_rdata;
    // stage b: shade read
    logic              r_b_valid;
    t_item             r_b_item;
    logic [BYTE_W-1:0] r_b_texel;
    logic [BYTE_W-1:0] shade_raddr;
    logic [BYTE_W-1:0] shade_rdata;
    // stage c: blend read
    logic              r_c_valid;
    t_kind             r_c_kind;
    logic [BYTE_W-1:0] r_c_old;
    logic              r_c_last;
    logic [BYTE_W-1:0] r_c_shaded;
    logic              r_c_skip;
    logic [ADDR_W-1:0] blend_raddr;
    logic [BYTE_W-1:0] blend_rdata;
    logic              masked_mode;
    logic              b_skip;
    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_new_pixel;
    logic              r_write_enable;
    logic              r_span_end;
    logic [BYTE_W-1:0] n_new_pixel;

    assign adv   = !r_out_valid || !i_out_stall;
    assign o_pop = adv && i_valid;

    fstb_ram #(.WIDTH(BYTE_W), .DEPTH(TEX_DEPTH)) u_texel_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && (i_item.kind == KIND_TEXEL_WRITE)),
        .i_waddr (i_item.addr[TIDX_W-1:0]),
        .i_wdata (i_item.data),
        .i_re    (adv),
        .i_raddr (i_item.addr[TIDX_W-1:0]),
        .o_rdata (texel_rdata)
    );

    assign shade_raddr = (i_draw_mode == MODE_CHECKER) ? checker_value(r_a_item.chk)
                                                       : texel_rdata;

    fstb_ram #(.WIDTH(BYTE_W), .DEPTH(SHADE_DEPTH)) u_shade_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_a_valid && (r_a_item.kind == KIND_SHADE_WRITE)),
        .i_waddr (r_a_item.addr[BYTE_W-1:0]),
        .i_wdata (r_a_item.data),
        .i_re    (adv),
        .i_raddr (shade_raddr),
        .o_rdata (shade_rdata)
    );

    assign masked_mode = (i_draw_mode != MODE_BLEND_SH) && (i_draw_mode != MODE_BLEND_DH)
                      && (i_draw_mode != MODE_CHECKER);
    assign b_skip      = masked_mode && (r_b_texel == i_mask_color);

    always_comb begin
        case (i_draw_mode)
            MODE_MASK_BLEND_SH, MODE_BLEND_SH: blend_raddr = {shade_rdata, r_b_item.data};
            MODE_MASK_BLEND_DH, MODE_BLEND_DH: blend_raddr = {r_b_item.data, shade_rdata};
            default:                           blend_raddr = {shade_rdata, r_b_item.data};
        endcase
    end

    fstb_ram #(.WIDTH(BYTE_W), .DEPTH(BLEND_DEPTH)) u_blend_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_b_valid && (r_b_item.kind == KIND_BLEND_WRITE)),
        .i_waddr (r_b_item.addr),
        .i_wdata (r_b_item.data),
        .i_re    (adv),
        .i_raddr (blend_raddr),
        .o_rdata (blend_rdata)
    );

    always_comb begin
        case (i_draw_mode)
            MODE_MASK_BLEND_SH, MODE_MASK_BLEND_DH, MODE_BLEND_SH, MODE_BLEND_DH: begin
                n_new_pixel = r_c_skip ? r_c_old : blend_rdata;
            end
            MODE_CHECKER: begin
                n_new_pixel = r_c_shaded;
            end
            default: begin
                n_new_pixel = r_c_skip ? r_c_old : r_c_shaded;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_item       <= i_item;
            r_b_item       <= r_a_item;
            r_b_texel      <= texel_rdata;
            r_c_kind       <= r_b_item.kind;
            r_c_old        <= r_b_item.data;
            r_c_last       <= r_b_item.last;
            r_c_shaded     <= shade_rdata;
            r_c_skip       <= b_skip;
            r_new_pixel    <= n_new_pixel;
            r_write_enable <= !r_c_skip;
            r_span_end     <= r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid && (r_c_kind == KIND_PIXEL);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_pixel    = r_new_pixel;
    assign o_write_enable = r_write_enable;
    assign o_span_end     = r_span_end;

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=>
            ($stable(r_a_valid) && $stable(r_b_valid) && $stable(r_c_valid)))
        else $error("pipeline moved during output stall");

    a_pixel_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_c_valid && (r_c_kind == KIND_PIXEL)) |=> r_out_valid)
        else $error("pixel lost before result register");

    a_write_kept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (!r_c_valid || (r_c_kind != KIND_PIXEL))) |=> !r_out_valid)
        else $error("result from a non-pixel beat");

endmodule

`default_nettype wire

FILE: sv/flat_span_texture_blend.sv
// top level of the flat span texturer with translucency
//
//  channel  direction  handshake                    payload
//  in       input      i_in_valid / o_in_stall      func, table_addr, table_data, u/v start
//                                                   and step, old_pixel, span_last
//  out      output     o_out_valid / i_out_stall    new_pixel, write_enable, span_end
//  cfg      input      i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
//  one beat per cycle sustained on both channels while neither stalls; a pixel
//  reaches out through the queue, texel read, shade read, blend read and result reg
//  span start acts on the very next beat; table writes go down the same pipe so
//  they stay ordered against pixel lookups
//  reset clears accumulators, config, queue and stage valids; the tables keep
//  whatever they hold until written
//  an out stall freezes the back pipe; the four-entry queue fills, then in stalls
`default_nettype none

module flat_span_texture_blend
    import fstb_pkg::*;
#(
    parameter int unsigned TEX_SIDE_BITS = 6,
    parameter int unsigned FRAC_BITS     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [BYTE_W-1:0]  i_cfg_data,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [ADDR_W-1:0]  i_table_addr,
    input  wire logic [BYTE_W-1:0]  i_table_data,
    input  wire logic [COORD_W-1:0] i_u_start,
    input  wire logic [COORD_W-1:0] i_v_start,
    input  wire logic [COORD_W-1:0] i_u_step,
    input  wire logic [COORD_W-1:0] i_v_step,
    input  wire logic [BYTE_W-1:0]  i_old_pixel,
    input  wire logic               i_span_last,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      logic [BYTE_W-1:0]  o_new_pixel,
    output      logic               o_write_enable,
    output      logic               o_span_end
);

    logic [MODE_W-1:0] r_draw_mode;
    logic [BYTE_W-1:0] r_mask_color;

    logic  q_full, q_valid, push, pop;
    t_item push_item, head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode  <= MODE_MASK_REPLACE;
            r_mask_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRAW_MODE:  r_draw_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_MASK_COLOR: r_mask_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;

    fstb_front #(
        .TEX_SIDE_BITS (TEX_SIDE_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_func       (i_func),
        .i_table_addr (i_table_addr),
        .i_table_data (i_table_data),
        .i_u_start    (i_u_start),
        .i_v_start    (i_v_start),
        .i_u_step     (i_u_step),
        .i_v_step     (i_v_step),
        .i_old_pixel  (i_old_pixel),
        .i_span_last  (i_span_last),
        .i_full       (q_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    fstb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    fstb_back #(
        .TEX_SIDE_BITS (TEX_SIDE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (head_item),
        .o_pop          (pop),
        .i_draw_mode    (r_draw_mode),
        .i_mask_color   (r_mask_color),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable),
        .o_span_end     (o_span_end)
    );

endmodule

`default_nettype wire
